// ===== src/pvc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pvc_pkg
// Shared types, register indexes and reset values of the PID valve controller.
// ----------------------------------------------------------------------------
package pvc_pkg;

	localparam int DataW = 16;
	localparam int GainW = 15;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TARGET    = 3'd0,
		REG_GAIN_P    = 3'd1,
		REG_GAIN_D    = 3'd2,
		REG_GAIN_I    = 3'd3,
		REG_ILIMIT    = 3'd4,
		REG_SLOW_DIV  = 3'd5,
		REG_SLOW_LIM  = 3'd6
	} cfg_reg_t;

	localparam logic signed [15:0] RstTarget   = 16'sd0;
	localparam logic [14:0]        RstGainP    = 15'd150;
	localparam logic [14:0]        RstGainD    = 15'd10;
	localparam logic [14:0]        RstGainI    = 15'd2;
	localparam logic [14:0]        RstILimit   = 15'd20000;
	localparam logic [7:0]         RstSlowDiv  = 8'd2;
	localparam logic signed [7:0]  RstSlowLim  = 8'sd100;
	localparam logic signed [15:0] RstIntegral = -16'sd15000;
	localparam logic [7:0]         ValveMid    = 8'd128;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_D,
		ST_DIV_D,
		ST_MUL_I,
		ST_MUL_IDT,
		ST_SLOW,
		ST_DIV_S,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [15:0] measured_temp;
		logic [31:0] time_now;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  valve_position;
		logic [15:0] integral_value;
	} out_item_t;

	typedef struct packed {
		logic [CfgIdxW-1:0]  index;
		logic [CfgDataW-1:0] data;
	} cfg_item_t;

endpackage
`default_nettype wire

// ===== src/pvc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pvc_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface pvc_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/pid_valve_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pid_valve_controller
// PID temperature loop with clamped integral driving a valve position.
// ----------------------------------------------------------------------------
// One transaction at a time. Multiplies are shift-add, one bit per cycle, and
// divides are restoring, one quotient bit per cycle, all on a single 16-bit
// shift datapath. The passes are followed by the slow check, the accumulate
// and the output states. The derivative multiply and divide are skipped when
// the elapsed time is zero, and a further divide pass runs when a positive
// increment is slowed by the divisor. The block returns to idle as the result
// is taken into the output register, and then accepts the next sample.
module pid_valve_controller (
	input wire clk,
	input wire arst_n,
	pvc_if.sink   in_ch,
	pvc_if.sink   cfg,
	pvc_if.source out_ch
);
	import pvc_pkg::*;

	logic signed [15:0] target_q;
	logic [14:0] gain_p_q, gain_d_q, gain_i_q, ilimit_q;
	logic [7:0] slow_div_q;
	logic signed [7:0] slow_lim_q;
	logic signed [15:0] integ_q, last_err_q;
	logic [7:0] last_time_q;

	state_t state_q, state_d;
	logic [3:0] cnt_q;
	logic signed [15:0] e_q, up_q, ud_q, inc_q;
	logic [7:0] dt_q;
	logic [15:0] mcand_q, mplier_q, prod_q;
	logic [15:0] quo_q, rem_q, dvd_q;
	logic neg_q;
	logic out_valid_q;
	out_item_t out_q;

	logic in_acc, cfg_acc, out_acc;
	assign in_acc  = in_ch.valid && in_ch.ready;
	assign cfg_acc = cfg.valid && cfg.ready;
	assign out_acc = out_ch.valid && out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;

	// serial step values
	logic [15:0] prod_add, rem_sh;
	logic [16:0] rem_sub;
	assign prod_add = mplier_q[0] ? prod_q + mcand_q : prod_q;
	assign rem_sh   = {rem_q[14:0], dvd_q[15]};
	assign rem_sub  = {1'b0, rem_sh} - {1'b0, mcand_q};

	logic signed [15:0] err_n, de;
	assign err_n = target_q - $signed(in_ch.payload.measured_temp);
	assign de    = e_q - last_err_q;

	logic signed [16:0] acc_w, lim_w;
	logic signed [15:0] acc_c, result;
	assign acc_w = 17'(integ_q) + 17'(inc_q);
	assign lim_w = {2'b0, ilimit_q};
	always_comb begin
		if (acc_w > lim_w)
			acc_c = 16'(lim_w);
		else if (acc_w < -lim_w)
			acc_c = 16'(-lim_w);
		else
			acc_c = 16'(acc_w);
	end
	assign result = up_q + ud_q + integ_q;

	logic signed [15:0] res_div;
	assign res_div = (result < 0) ? -16'(16'(-result) >> 8)
	                              : (result >>> 8);

	logic signed [15:0] up_div;
	assign up_div = (up_q < 0) ? -16'(16'(-up_q) >> 8) : (up_q >>> 8);

	logic signed [15:0] quo_s;
	assign quo_s = neg_q ? 16'(-quo_q) : quo_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_acc) state_d = ST_MUL_P;
			ST_MUL_P:   if (cnt_q == 4'd15) state_d = (dt_q == 8'd0) ? ST_MUL_I : ST_MUL_D;
			ST_MUL_D:   if (cnt_q == 4'd15) state_d = ST_DIV_D;
			ST_DIV_D:   if (cnt_q == 4'd15) state_d = ST_MUL_I;
			ST_MUL_I:   if (cnt_q == 4'd15) state_d = ST_MUL_IDT;
			ST_MUL_IDT: if (cnt_q == 4'd15) state_d = ST_SLOW;
			ST_SLOW:    state_d = (inc_q > 0 && up_div > 16'(slow_lim_q) &&
			                       slow_div_q != 8'd0) ? ST_DIV_S : ST_ACC;
			ST_DIV_S:   if (cnt_q == 4'd15) state_d = ST_ACC;
			ST_ACC:     state_d = ST_OUT;
			ST_OUT:     if (!out_valid_q || out_acc) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			target_q <= RstTarget;
			gain_p_q <= RstGainP;
			gain_d_q <= RstGainD;
			gain_i_q <= RstGainI;
			ilimit_q <= RstILimit;
			slow_div_q <= RstSlowDiv;
			slow_lim_q <= RstSlowLim;
			integ_q <= RstIntegral;
			last_err_q <= '0;
			last_time_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_d != state_q) ? 4'd0 : cnt_q + 4'd1;
			if (cfg_acc) begin
				case (cfg.payload.index)
					REG_TARGET:   target_q <= cfg.payload.data;
					REG_GAIN_P:   gain_p_q <= cfg.payload.data[14:0];
					REG_GAIN_D:   gain_d_q <= cfg.payload.data[14:0];
					REG_GAIN_I:   gain_i_q <= cfg.payload.data[14:0];
					REG_ILIMIT:   ilimit_q <= cfg.payload.data[14:0];
					REG_SLOW_DIV: slow_div_q <= cfg.payload.data[7:0];
					REG_SLOW_LIM: slow_lim_q <= cfg.payload.data[7:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: if (in_acc) last_time_q <= in_ch.payload.time_now[7:0];
				ST_ACC: integ_q <= acc_c;
				default: ;
			endcase
			if (state_q == ST_OUT && (!out_valid_q || out_acc)) begin
				out_valid_q <= 1'b1;
				last_err_q <= e_q;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_acc) begin
				e_q <= err_n;
				dt_q <= in_ch.payload.time_now[7:0] - last_time_q;
				mcand_q <= err_n;
				mplier_q <= {1'b0, gain_p_q};
				prod_q <= '0;
				ud_q <= '0;
			end
			ST_MUL_P, ST_MUL_D, ST_MUL_I, ST_MUL_IDT: begin
				if (cnt_q == 4'd15) begin
					case (state_q)
						ST_MUL_P: begin
							up_q <= prod_add;
							prod_q <= '0;
							if (dt_q == 8'd0) begin
								mcand_q <= e_q;
								mplier_q <= {1'b0, gain_i_q};
							end else begin
								mcand_q <= de;
								mplier_q <= {1'b0, gain_d_q};
							end
						end
						ST_MUL_D: begin
							rem_q <= '0;
							quo_q <= '0;
							neg_q <= prod_add[15];
							dvd_q <= prod_add[15] ? 16'(-prod_add) : prod_add;
							mcand_q <= {8'd0, dt_q};
						end
						ST_MUL_I: begin
							mcand_q <= prod_add;
							mplier_q <= {8'd0, dt_q};
							prod_q <= '0;
						end
						default: begin
							inc_q <= prod_add[15] ? -16'($signed(16'(-prod_add) >> 4))
							                      : 16'(prod_add >> 4);
						end
					endcase
				end else begin
					prod_q <= prod_add;
					mcand_q <= {mcand_q[14:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[15:1]};
				end
			end
			ST_DIV_D, ST_DIV_S: begin
				dvd_q <= {dvd_q[14:0], 1'b0};
				if (!rem_sub[16]) begin
					rem_q <= rem_sub[15:0];
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[14:0], 1'b0};
				end
				if (state_q == ST_DIV_D && cnt_q == 4'd15) begin
					mcand_q <= e_q;
					mplier_q <= {1'b0, gain_i_q};
					prod_q <= '0;
				end
			end
			ST_SLOW: begin
				rem_q <= '0;
				quo_q <= '0;
				neg_q <= 1'b0;
				dvd_q <= inc_q;
				mcand_q <= {8'd0, slow_div_q};
			end
			default: ;
		endcase
		if (state_q == ST_MUL_I && cnt_q == 4'd0 && dt_q != 8'd0)
			ud_q <= {quo_s[7:0], 8'd0};
		if (state_q == ST_DIV_S && cnt_q == 4'd15)
			inc_q <= !rem_sub[16] ? {quo_q[14:0], 1'b1} : {quo_q[14:0], 1'b0};
		if (state_q == ST_OUT && (!out_valid_q || out_acc)) begin
			out_q.valve_position <= ValveMid + res_div[7:0];
			out_q.integral_value <= integ_q;
		end
	end

endmodule
`default_nettype wire

// ===== dv/pid_valve_controller_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_valve_controller_tb
// Drives temperature samples through the PID valve controller and compares
// every result with a behavioral model of the loop. Registers are
// reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module pid_valve_controller_tb;
	import pvc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	pvc_if #(.T(in_item_t))  in_ch ();
	pvc_if #(.T(cfg_item_t)) cfg ();
	pvc_if #(.T(out_item_t)) out_ch ();

	pid_valve_controller DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .cfg(cfg), .out_ch(out_ch)
	);

	// model state and registers
	int m_target, m_gp, m_gd, m_gi, m_ilim, m_sdiv, m_slim;
	int m_acc, m_lerr;
	bit [7:0] m_ltime;

	in_item_t  sample_q[$];
	out_item_t valve_q[$];
	int errors = 0;
	int mismatches = 0;
	int cycles = 0;
	bit idle_en = 1'b1;
	bit hold_rx = 1'b0;
	bit hold_tx = 1'b0;

	function automatic int w16(int v);
		return int'($signed(v[15:0]));
	endfunction

	function automatic out_item_t pid_step(in_item_t it);
		out_item_t r;
		int meas, dt, e, up, ud, inc, acc, res, valve;
		meas = int'($signed(it.measured_temp));
		dt = int'(8'(it.time_now[7:0] - m_ltime));
		e = w16(m_target - meas);
		up = w16(m_gp * e);
		ud = 0;
		if (dt != 0)
			ud = w16((w16(m_gd * w16(e - m_lerr)) / dt) * 256);
		inc = w16(w16(m_gi * e) * dt) / 16;
		if (inc > 0 && (up / 256) > m_slim && m_sdiv != 0)
			inc = inc / m_sdiv;
		acc = m_acc + inc;
		if (acc > m_ilim)
			acc = m_ilim;
		else if (acc < -m_ilim)
			acc = -m_ilim;
		m_acc = acc;
		res = w16(up + ud + acc);
		valve = 128 + res / 256;
		m_lerr = e;
		m_ltime = it.time_now[7:0];
		r.valve_position = valve[7:0];
		r.integral_value = acc[15:0];
		return r;
	endfunction

	function automatic void model_cfg(cfg_reg_t idx, logic [15:0] d);
		case (idx)
			REG_TARGET:   m_target = int'($signed(d));
			REG_GAIN_P:   m_gp = int'(d[14:0]);
			REG_GAIN_D:   m_gd = int'(d[14:0]);
			REG_GAIN_I:   m_gi = int'(d[14:0]);
			REG_ILIMIT:   m_ilim = int'(d[14:0]);
			REG_SLOW_DIV: m_sdiv = int'(d[7:0]);
			REG_SLOW_LIM: m_slim = int'($signed(d[7:0]));
			default: ;
		endcase
	endfunction

	// driver
	int tx_gap = 0;
	bit tx_done = 1'b0;
	initial begin
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
	end
	always @(negedge clk) begin : drive
		logic accepted;
		accepted = tx_done;
		if (accepted || !in_ch.valid) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (!hold_tx && sample_q.size() > 0
					&& !(idle_en && $urandom_range(0, 9) == 0)) begin
				in_ch.payload <= sample_q.pop_front();
				in_ch.valid <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
				if (idle_en && $urandom_range(0, 9) == 0)
					tx_gap <= $urandom_range(1, 13);
			end
		end
	end

	// expected results are formed when a sample is accepted
	always @(posedge clk) begin
		tx_done <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready)
			valve_q.push_back(pid_step(in_ch.payload));
	end

	// monitor
	always @(posedge clk) begin : monitor
		out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (valve_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected result %p", out_ch.payload);
			end else begin
				want = valve_q.pop_front();
				if (want.valve_position !== out_ch.payload.valve_position
						|| want.integral_value !== out_ch.payload.integral_value) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: expected %p got %p", want, out_ch.payload);
				end
			end
		end
	end

	// receiver ready
	int rx_gap = 0;
	initial out_ch.ready = 1'b0;
	always @(negedge clk) begin
		if (!arst_n || hold_rx) begin
			out_ch.ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			out_ch.ready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			rx_gap <= $urandom_range(1, 13);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("pid_valve_controller verification failed");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [15:0] d);
		@(negedge clk);
		cfg.payload <= '{index: idx, data: d};
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		model_cfg(idx, d);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		while (sample_q.size() > 0 || in_ch.valid || valve_q.size() > 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic push_sample(logic [15:0] t, logic [31:0] tm);
		in_item_t it;
		it.measured_temp = t;
		it.time_now = tm;
		sample_q.push_back(it);
	endtask

	task automatic random_cfg(bit extreme);
		write_reg(REG_TARGET, extreme ? ($urandom_range(0, 1) ? 16'h7fff : 16'h8000)
			: 16'($urandom));
		write_reg(REG_GAIN_P, extreme ? 16'h7fff : 16'($urandom_range(0, 400)));
		write_reg(REG_GAIN_D, extreme ? 16'h0000 : 16'($urandom));
		write_reg(REG_GAIN_I, extreme ? 16'h7fff : 16'($urandom_range(0, 50)));
		write_reg(REG_ILIMIT, extreme ? 16'h0000 : 16'($urandom));
		write_reg(REG_SLOW_DIV, extreme ? 16'h00ff : 16'($urandom_range(0, 255)));
		write_reg(REG_SLOW_LIM, extreme ? 16'h0080 : 16'($urandom));
	endtask

	task automatic random_run(int n);
		logic [31:0] tm;
		tm = $urandom;
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: tm = tm + $urandom_range(0, 3);
				1: tm = $urandom;
				default: tm = tm + $urandom_range(1, 60);
			endcase
			if ($urandom_range(0, 1))
				push_sample(16'($urandom), tm);
			else
				push_sample(16'(m_target + $urandom_range(0, 600) - 300), tm);
		end
	endtask

	initial begin
		cfg.valid = 1'b0;
		cfg.payload = '0;
		m_target = 0; m_gp = 150; m_gd = 10; m_gi = 2; m_ilim = 20000;
		m_sdiv = 2; m_slim = 100; m_acc = -15000; m_lerr = 0; m_ltime = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(posedge clk);

		// directed: defaults, field extremes, zero elapsed time
		push_sample(16'h0000, 32'd0);
		push_sample(16'h7fff, 32'd10);
		push_sample(16'h8000, 32'd10);
		push_sample(16'hffff, 32'hffffffff);
		push_sample(16'h0001, 32'h00000100);
		push_sample(16'h0000, 32'h000000ff);
		drain();
		write_reg(REG_SLOW_DIV, 16'h0000);
		write_reg(REG_SLOW_LIM, 16'h0080);
		write_reg(REG_GAIN_P, 16'hffff);
		write_reg(REG_GAIN_I, 16'h7fff);
		write_reg(REG_ILIMIT, 16'h7fff);
		write_reg(REG_TARGET, 16'h7fff);
		write_reg(REG_GAIN_D, 16'h7fff);
		push_sample(16'h8000, 32'h5555aaaa);
		push_sample(16'h7fff, 32'haaaa5555);
		push_sample(16'h0000, 32'haaaa5555);
		push_sample(16'h1234, 32'haaaa5556);
		drain();
		write_reg(REG_SLOW_DIV, 16'h0001);
		write_reg(REG_SLOW_LIM, 16'h007f);
		write_reg(REG_TARGET, 16'h8000);
		write_reg(REG_ILIMIT, 16'h0000);
		push_sample(16'h7fff, 32'd3);
		push_sample(16'h8000, 32'd200);
		push_sample(16'h0100, 32'd1);
		drain();

		// long receiver stall while samples keep coming
		hold_rx = 1'b1;
		random_run(30);
		repeat (800) @(posedge clk);
		hold_rx = 1'b0;
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			random_cfg(ph == 3 || ph == 7);
			if (ph == 11)
				idle_en = 1'b0;
			random_run(115);
			if (ph == 5) begin
				while (sample_q.size() > 60) @(posedge clk);
				hold_tx = 1'b1;
				while (valve_q.size() > 0 || in_ch.valid) @(posedge clk);
				hold_tx = 1'b0;
			end
			drain();
		end

		if (errors == 0)
			$display("pid_valve_controller verification clean");
		else
			$display("pid_valve_controller verification failed");
		$finish;
	end
endmodule

// ===== pid_valve_controller.f =====
src/pvc_pkg.sv
src/pvc_if.sv
src/pid_valve_controller.sv
dv/pid_valve_controller_tb.sv
